// ===== rtl/mfde_pkg.sv =====
// Shared types, codes and the 5x7 font table for the monochrome frame buffer draw engine.
// No dependencies; imported by mfde_store and mono_framebuffer_draw_engine.
package mfde_pkg;

    localparam int CRD_W = 20;
    typedef logic signed [CRD_W-1:0] t_coord;

    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_PIXEL   = 3'd1;
    localparam logic [2:0] ACT_LINE    = 3'd2;
    localparam logic [2:0] ACT_FILL    = 3'd3;
    localparam logic [2:0] ACT_OUTLINE = 3'd4;
    localparam logic [2:0] ACT_GLYPH   = 3'd5;
    localparam logic [2:0] ACT_READ    = 3'd6;
    localparam logic [2:0] ACT_UNUSED  = 3'd7;

    localparam logic [7:0] GLYPH_FIRST    = 8'd32;
    localparam logic [7:0] GLYPH_LAST     = 8'd90;
    localparam logic [5:0] GLYPH_FALLBACK = 6'd31;  // '?' minus first code
    localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
    localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_STORE_WAIT, S_READ_WAIT, S_RESULT,
        S_LINE_SETUP, S_LINE_INIT, S_LINE_ERR, S_LINE_PLOT, S_LINE_WAIT, S_LINE_STEP,
        S_RECT_SETUP, S_RECT_PLOT, S_RECT_WAIT, S_GLYPH_DOT, S_GLYPH_NEXT
    } t_state;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FILL, ST_ROT, ST_MUL, ST_RD, ST_WR, ST_RDA, ST_RDB
    } t_st_state;

    typedef enum logic [1:0] {SOP_NONE, SOP_PLOT, SOP_FILL, SOP_READ} t_sop;

    typedef struct packed {
        t_sop        op;
        t_coord      x;
        t_coord      y;
        logic        white;
        logic [7:0]  fill_byte;
        logic [15:0] addr;
    } t_sreq;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] data;
    } t_srsp;

    function automatic logic [7:0] glyph_column(input logic [5:0] idx, input logic [2:0] col);
        logic [39:0] g;
        case (idx)
            6'd0:  g = 40'h0000000000;  6'd1:  g = 40'h00005F0000;
            6'd2:  g = 40'h0007000700;  6'd3:  g = 40'h147F147F14;
            6'd4:  g = 40'h242A7F2A12;  6'd5:  g = 40'h2313086462;
            6'd6:  g = 40'h3649552250;  6'd7:  g = 40'h0005030000;
            6'd8:  g = 40'h001C224100;  6'd9:  g = 40'h0041221C00;
            6'd10: g = 40'h082A1C2A08;  6'd11: g = 40'h08083E0808;
            6'd12: g = 40'h0050300000;  6'd13: g = 40'h0808080808;
            6'd14: g = 40'h0060600000;  6'd15: g = 40'h2010080402;
            6'd16: g = 40'h3E5149453E;  6'd17: g = 40'h00427F4000;
            6'd18: g = 40'h4261514946;  6'd19: g = 40'h2141454B31;
            6'd20: g = 40'h1814127F10;  6'd21: g = 40'h2745454539;
            6'd22: g = 40'h3C4A494930;  6'd23: g = 40'h0171090503;
            6'd24: g = 40'h3649494936;  6'd25: g = 40'h064949291E;
            6'd26: g = 40'h0036360000;  6'd27: g = 40'h0056360000;
            6'd28: g = 40'h0814224100;  6'd29: g = 40'h1414141414;
            6'd30: g = 40'h0041221408;  6'd31: g = 40'h0201510906;
            6'd32: g = 40'h324979413E;  6'd33: g = 40'h7E1111117E;
            6'd34: g = 40'h7F49494936;  6'd35: g = 40'h3E41414122;
            6'd36: g = 40'h7F4141221C;  6'd37: g = 40'h7F49494941;
            6'd38: g = 40'h7F09090101;  6'd39: g = 40'h3E41415132;
            6'd40: g = 40'h7F0808087F;  6'd41: g = 40'h00417F4100;
            6'd42: g = 40'h2040413F01;  6'd43: g = 40'h7F08142241;
            6'd44: g = 40'h7F40404040;  6'd45: g = 40'h7F020C027F;
            6'd46: g = 40'h7F0408107F;  6'd47: g = 40'h3E4141413E;
            6'd48: g = 40'h7F09090906;  6'd49: g = 40'h3E4151215E;
            6'd50: g = 40'h7F09192946;  6'd51: g = 40'h4649494931;
            6'd52: g = 40'h01017F0101;  6'd53: g = 40'h3F4040403F;
            6'd54: g = 40'h1F2040201F;  6'd55: g = 40'h3F4038403F;
            6'd56: g = 40'h6314081463;  6'd57: g = 40'h0708700807;
            6'd58: g = 40'h6151494543;
            default: g = 40'h0000000000;
        endcase
        case (col)
            3'd0:    glyph_column = g[39:32];
            3'd1:    glyph_column = g[31:24];
            3'd2:    glyph_column = g[23:16];
            3'd3:    glyph_column = g[15:8];
            default: glyph_column = g[7:0];
        endcase
    endfunction

endpackage

// ===== rtl/mfde_store.sv =====
// Frame store with its pixel unit: clip, rotate, address multiply, read-modify-write,
// plus fill sweep and byte read. Depends on mfde_pkg.
module mfde_store import mfde_pkg::*; #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_orient,
    input  t_sreq      i_req,
    output t_srsp      o_rsp
);
    localparam int FRAME_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int BW = AW + 3;
    localparam int CW = $clog2((PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT);

    logic [7:0] mem [0:FRAME_BYTES-1];
    logic [7:0] r_mem_q;

    t_st_state r_st, n_st;
    logic [AW-1:0] r_cnt;
    logic [7:0]    r_fill;
    t_coord        r_px, r_py;
    logic          r_white;
    logic [CW-1:0] r_rx, r_ry;
    logic [BW-1:0] r_bit;
    logic [15:0]   r_addr;
    logic          r_addr_ok;
    logic [7:0]    r_rsp_data;

    t_coord        lw, lh;
    logic          inb;
    logic [CW-1:0] xn, yn, rx, ry;
    logic          w_we, w_done;
    logic [AW-1:0] w_wa, w_ra;
    logic [7:0]    w_wd, mask;

    assign lw = i_orient[0] ? t_coord'(PANEL_HEIGHT) : t_coord'(PANEL_WIDTH);
    assign lh = i_orient[0] ? t_coord'(PANEL_WIDTH) : t_coord'(PANEL_HEIGHT);
    assign inb = !r_px[CRD_W-1] && !r_py[CRD_W-1] && (r_px < lw) && (r_py < lh);
    assign xn = r_px[CW-1:0];
    assign yn = r_py[CW-1:0];
    assign mask = 8'h80 >> r_bit[2:0];

    always_comb begin
        case (i_orient)
            2'd0: begin rx = xn; ry = yn; end
            2'd1: begin rx = yn; ry = CW'(PANEL_HEIGHT - 1) - xn; end
            2'd2: begin rx = CW'(PANEL_WIDTH - 1) - xn; ry = CW'(PANEL_HEIGHT - 1) - yn; end
            default: begin rx = CW'(PANEL_WIDTH - 1) - yn; ry = xn; end
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: begin
                case (i_req.op)
                    SOP_PLOT: n_st = ST_ROT;
                    SOP_FILL: n_st = ST_FILL;
                    SOP_READ: n_st = ST_RDA;
                    default:  n_st = ST_IDLE;
                endcase
            end
            ST_FILL: if (r_cnt == AW'(FRAME_BYTES - 1)) n_st = ST_IDLE;
            ST_ROT:  n_st = inb ? ST_MUL : ST_IDLE;
            ST_MUL:  n_st = ST_RD;
            ST_RD:   n_st = ST_WR;
            ST_WR:   n_st = ST_IDLE;
            ST_RDA:  n_st = ST_RDB;
            ST_RDB:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_we   = 1'b0;
        w_done = 1'b0;
        w_wa   = AW'(r_bit >> 3);
        w_ra   = AW'(r_bit >> 3);
        w_wd   = r_white ? (r_mem_q | mask) : (r_mem_q & ~mask);
        unique case (r_st)
            ST_FILL: begin
                w_we = 1'b1;
                w_wa = r_cnt;
                w_wd = r_fill;
                w_done = (r_cnt == AW'(FRAME_BYTES - 1));
            end
            ST_ROT:  w_done = !inb;
            ST_WR: begin
                w_we = 1'b1;
                w_done = 1'b1;
            end
            ST_RDA:  w_ra = r_addr_ok ? AW'(r_addr) : '0;
            ST_RDB:  w_done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_mem_q <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_FILL;
            r_cnt  <= '0;
            r_fill <= 8'hFF;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    r_cnt     <= '0;
                    r_fill    <= i_req.fill_byte;
                    r_px      <= i_req.x;
                    r_py      <= i_req.y;
                    r_white   <= i_req.white;
                    r_addr    <= i_req.addr;
                    r_addr_ok <= ({4'b0, i_req.addr} < 20'(FRAME_BYTES));
                end
                ST_FILL: r_cnt <= r_cnt + 1'b1;
                ST_ROT: begin
                    r_rx <= rx;
                    r_ry <= ry;
                end
                ST_MUL:  r_bit <= BW'(r_ry) * BW'(PANEL_WIDTH) + BW'(r_rx);
                ST_RDB:  r_rsp_data <= r_addr_ok ? r_mem_q : 8'h00;
                default: ;
            endcase
        end
    end

    assign o_rsp.busy = (r_st != ST_IDLE);
    assign o_rsp.done = w_done;
    assign o_rsp.data = r_rsp_data;

endmodule

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// Clear: the store sweeps every frame byte, one store byte per cycle.
// Every plotted pixel passes through the shared pixel unit (clip/rotate, address
// multiply, store read, store write); a read-byte command returns its byte through the
// result register. Rectangle and glyph points go through the pixel unit after their setup,
// line points also through a Bresenham step state; a clipped point ends at clip/rotate.
// Throughput: one command at a time; not ready while a command runs.
// Reset: synchronous active-low; orientation goes to landscape, then a clearing pass writes
// white to all store bytes before the first command is taken.
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480,
    parameter int MAX_SCALE    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x_or_width,
    input  logic signed [15:0] i_end_y_or_height,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic [3:0]  i_scale,
    input  logic [15:0] i_byte_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data
);
    t_state r_state, n_state;
    logic [1:0] r_orient;

    // command fields
    logic [2:0]  r_action;
    t_coord      r_cx, r_cy, r_cw, r_ch;
    logic [5:0]  r_gidx;
    logic [3:0]  r_scale;
    logic        r_white;
    logic [7:0]  r_color;
    logic [15:0] r_addr;

    // line walker
    t_coord r_lx, r_ly, r_lx1, r_ly1, r_dx, r_dy, r_err;
    logic   r_sx_neg, r_sy_neg, r_outline;
    logic [1:0] r_seg;

    // rectangle walker
    t_coord r_rx, r_ry, r_rw, r_rh, r_i, r_j, r_xa, r_xb, r_yb;

    // glyph walker
    logic [2:0] r_col, r_row;
    logic       r_glyph;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_data;

    t_sreq sreq;
    t_srsp srsp;

    mfde_store #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PANEL_HEIGHT(PANEL_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_orient(r_orient),
        .i_req   (sreq),
        .o_rsp   (srsp)
    );

    // logical bounds of the current orientation
    t_coord lw, lh;
    assign lw = r_orient[0] ? t_coord'(PANEL_HEIGHT) : t_coord'(PANEL_WIDTH);
    assign lh = r_orient[0] ? t_coord'(PANEL_WIDTH) : t_coord'(PANEL_HEIGHT);

    logic accept;
    assign o_ready = (r_state == S_IDLE) && !srsp.busy;
    assign accept  = i_valid && o_ready;

    // outline segment endpoints: top, bottom, left, right edge
    t_coord xe, ye, seg_x0, seg_y0, seg_x1, seg_y1;
    assign xe = r_cx + r_cw - t_coord'(1);
    assign ye = r_cy + r_ch - t_coord'(1);
    always_comb begin
        seg_x0 = r_cx; seg_y0 = r_cy; seg_x1 = r_cw; seg_y1 = r_ch;
        if (r_outline) begin
            case (r_seg)
                2'd0: begin seg_x1 = xe;   seg_y1 = r_cy; end
                2'd1: begin seg_y0 = ye;   seg_x1 = xe; seg_y1 = ye; end
                2'd2: begin seg_x1 = r_cx; seg_y1 = ye; end
                default: begin seg_x0 = xe; seg_x1 = xe; seg_y1 = ye; end
            endcase
        end
    end

    // Bresenham step: both error updates come from the pre-step error
    logic signed [CRD_W:0] e2;
    logic   step_x, step_y, line_end;
    t_coord n_err;
    assign e2       = {r_err, 1'b0};
    assign step_x   = e2 >= $signed({r_dy[CRD_W-1], r_dy});
    assign step_y   = e2 <= $signed({r_dx[CRD_W-1], r_dx});
    assign n_err    = r_err + (step_x ? r_dy : '0) + (step_y ? r_dx : '0);
    assign line_end = (r_lx == r_lx1) && (r_ly == r_ly1);

    // rectangle clip against logical bounds
    t_coord rxa, rya, rxb, ryb, rsx, rsy;
    logic   rect_empty, rect_last_x, rect_last_y;
    assign rsx = r_rx + r_rw;
    assign rsy = r_ry + r_rh;
    assign rxa = r_rx[CRD_W-1] ? '0 : r_rx;
    assign rya = r_ry[CRD_W-1] ? '0 : r_ry;
    assign rxb = (rsx > lw) ? lw : rsx;
    assign ryb = (rsy > lh) ? lh : rsy;
    assign rect_empty  = (rxa >= rxb) || (rya >= ryb);
    assign rect_last_x = (r_i + t_coord'(1)) >= r_xb;
    assign rect_last_y = (r_j + t_coord'(1)) >= r_yb;

    // glyph dot lookup and cell origin
    logic [7:0] gcol;
    logic       gbit;
    logic [6:0] gofs_x, gofs_y;
    assign gcol   = glyph_column(r_gidx, r_col);
    assign gbit   = gcol[r_row];
    assign gofs_x = 7'(r_col) * 7'(r_scale);
    assign gofs_y = 7'(r_row) * 7'(r_scale);

    // input decode
    logic [5:0] in_gidx;
    logic [3:0] in_scale;
    assign in_gidx  = (i_char_code < GLYPH_FIRST || i_char_code > GLYPH_LAST)
                    ? GLYPH_FALLBACK : 6'(i_char_code - GLYPH_FIRST);
    assign in_scale = ({1'b0, i_scale} > 5'(MAX_SCALE)) ? 4'(MAX_SCALE) : i_scale;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_CMD;
            S_CMD: begin
                case (r_action)
                    ACT_CLEAR, ACT_PIXEL:  n_state = S_STORE_WAIT;
                    ACT_LINE, ACT_OUTLINE: n_state = S_LINE_SETUP;
                    ACT_FILL:              n_state = S_RECT_SETUP;
                    ACT_GLYPH:             n_state = (r_scale == '0) ? S_IDLE : S_GLYPH_DOT;
                    ACT_READ:              n_state = S_READ_WAIT;
                    default:               n_state = S_IDLE;
                endcase
            end
            S_STORE_WAIT: if (srsp.done) n_state = S_IDLE;
            S_READ_WAIT:  if (srsp.done) n_state = S_RESULT;
            S_RESULT:     if (!r_out_valid || i_ready) n_state = S_IDLE;
            S_LINE_SETUP: n_state = S_LINE_INIT;
            S_LINE_INIT:  n_state = S_LINE_ERR;
            S_LINE_ERR:   n_state = S_LINE_PLOT;
            S_LINE_PLOT:  n_state = S_LINE_WAIT;
            S_LINE_WAIT: begin
                if (srsp.done) begin
                    if (!line_end)                   n_state = S_LINE_STEP;
                    else if (r_outline && r_seg != 2'd3) n_state = S_LINE_SETUP;
                    else                             n_state = S_IDLE;
                end
            end
            S_LINE_STEP:  n_state = S_LINE_PLOT;
            S_RECT_SETUP: begin
                if (!rect_empty)   n_state = S_RECT_PLOT;
                else if (r_glyph)  n_state = S_GLYPH_NEXT;
                else               n_state = S_IDLE;
            end
            S_RECT_PLOT:  n_state = S_RECT_WAIT;
            S_RECT_WAIT: begin
                if (srsp.done) begin
                    if (!rect_last_x || !rect_last_y) n_state = S_RECT_PLOT;
                    else if (r_glyph)                 n_state = S_GLYPH_NEXT;
                    else                              n_state = S_IDLE;
                end
            end
            S_GLYPH_DOT:  n_state = gbit ? S_RECT_SETUP : S_GLYPH_NEXT;
            S_GLYPH_NEXT: begin
                if (r_row == GLYPH_LAST_ROW && r_col == GLYPH_LAST_COL) n_state = S_IDLE;
                else                                                  n_state = S_GLYPH_DOT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store requests
    always_comb begin
        sreq.op        = SOP_NONE;
        sreq.x         = r_lx;
        sreq.y         = r_ly;
        sreq.white     = r_white;
        sreq.fill_byte = r_color;
        sreq.addr      = r_addr;
        unique case (r_state)
            S_CMD: begin
                case (r_action)
                    ACT_CLEAR: sreq.op = SOP_FILL;
                    ACT_PIXEL: begin
                        sreq.op = SOP_PLOT;
                        sreq.x  = r_cx;
                        sreq.y  = r_cy;
                    end
                    ACT_READ:  sreq.op = SOP_READ;
                    default:   sreq.op = SOP_NONE;
                endcase
            end
            S_LINE_PLOT: sreq.op = SOP_PLOT;
            S_RECT_PLOT: begin
                sreq.op = SOP_PLOT;
                sreq.x  = r_i;
                sreq.y  = r_j;
            end
            default: ;
        endcase
    end

    // orientation register and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_orient    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_orient <= i_cfg_data;
            end
            // load a new result when the slot frees up, else drop the held one once taken
            if (r_state == S_RESULT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= srsp.data;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    // hold the transfer's fields for the whole command
                    r_action  <= i_action;
                    r_cx      <= t_coord'(i_start_x);
                    r_cy      <= t_coord'(i_start_y);
                    r_cw      <= t_coord'(i_end_x_or_width);
                    r_ch      <= t_coord'(i_end_y_or_height);
                    r_gidx    <= in_gidx;
                    r_scale   <= in_scale;
                    r_white   <= (i_color != 8'h00);
                    r_color   <= i_color;
                    r_addr    <= i_byte_address;
                    r_outline <= (i_action == ACT_OUTLINE);
                    r_glyph   <= (i_action == ACT_GLYPH);
                    r_seg     <= 2'd0;
                    r_col     <= '0;
                    r_row     <= '0;
                end
                S_CMD: begin
                    r_rx <= r_cx;
                    r_ry <= r_cy;
                    r_rw <= r_cw;
                    r_rh <= r_ch;
                end
                S_LINE_SETUP: begin
                    r_lx  <= seg_x0;
                    r_ly  <= seg_y0;
                    r_lx1 <= seg_x1;
                    r_ly1 <= seg_y1;
                end
                S_LINE_INIT: begin
                    r_dx     <= (r_lx1 >= r_lx) ? (r_lx1 - r_lx) : (r_lx - r_lx1);
                    r_dy     <= (r_ly1 >= r_ly) ? (r_ly - r_ly1) : (r_ly1 - r_ly);
                    r_sx_neg <= !(r_lx < r_lx1);
                    r_sy_neg <= !(r_ly < r_ly1);
                end
                S_LINE_ERR: r_err <= r_dx + r_dy;
                S_LINE_WAIT: begin
                    if (srsp.done && line_end) begin
                        r_seg <= r_seg + 1'b1;
                    end
                end
                S_LINE_STEP: begin
                    r_err <= n_err;
                    if (step_x) begin
                        r_lx <= r_sx_neg ? r_lx - t_coord'(1) : r_lx + t_coord'(1);
                    end
                    if (step_y) begin
                        r_ly <= r_sy_neg ? r_ly - t_coord'(1) : r_ly + t_coord'(1);
                    end
                end
                S_RECT_SETUP: begin
                    r_i  <= rxa;
                    r_j  <= rya;
                    r_xa <= rxa;
                    r_xb <= rxb;
                    r_yb <= ryb;
                end
                S_RECT_WAIT: begin
                    // advance along the row, then wrap to the next row
                    if (srsp.done) begin
                        if (!rect_last_x) begin
                            r_i <= r_i + t_coord'(1);
                        end else begin
                            r_i <= r_xa;
                            r_j <= r_j + t_coord'(1);
                        end
                    end
                end
                S_GLYPH_DOT: begin
                    r_rx <= r_cx + t_coord'(gofs_x);
                    r_ry <= r_cy + t_coord'(gofs_y);
                    r_rw <= t_coord'(r_scale);
                    r_rh <= t_coord'(r_scale);
                end
                S_GLYPH_NEXT: begin
                    // walk rows of a column, then the next column
                    if (r_row == GLYPH_LAST_ROW) begin
                        r_row <= '0;
                        r_col <= r_col + 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule
